FILE: design/ptps_pkg.sv
// ----------------------------------------------------------------------------
// ptps_pkg
// Shared types and codes for the process table priority select block.
// ----------------------------------------------------------------------------
package ptps_pkg;

  localparam int unsigned DefaultMaxEntries = 16;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_PURGE  = 2'd3;

  // process state codes
  localparam logic [1:0] PST_READY      = 2'd0;
  localparam logic [1:0] PST_TERMINATED = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_POSITION = 2'd2;
  localparam logic [1:0] ERR_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] proc_id;
    logic [1:0]  proc_state;
    logic [7:0]  proc_priority;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic        found;
    logic [15:0] found_id;
    logic [7:0]  found_priority;
    logic [4:0]  entry_count;
  } out_item_t;

  // one table entry as held in the ram
  typedef struct packed {
    logic [15:0] pid;
    logic [1:0]  pst;
    logic [7:0]  prio;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: design/ptps_ram.sv
// ----------------------------------------------------------------------------
// ptps_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module ptps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ptps_datapath.sv
// ----------------------------------------------------------------------------
// ptps_datapath
// Entry table, scan counters, best-entry tracking and result register.
// ----------------------------------------------------------------------------
module ptps_datapath import ptps_pkg::*; #(
  parameter int unsigned MaxEntries = DefaultMaxEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_ctl_t   ctl_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  localparam int unsigned IW   = $clog2(MaxEntries);
  localparam int unsigned CW   = $clog2(MaxEntries + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;
  localparam int unsigned EW   = $bits(entry_t);

  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [CW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic          have_q, have_d;
  logic [15:0]   best_id_q, best_id_d;
  logic [7:0]    best_pr_q, best_pr_d;
  logic [1:0]    cmd_q, err_q, err_d;
  logic [7:0]    pos_q;
  entry_t        ins_q;
  out_item_t     out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        rd_entry;
  logic [EW-1:0] ram_rdata;
  logic          skip;
  logic          issue;
  logic [CW-1:0] occ_next;

  ptps_ram #(
    .Width (EW),
    .Depth (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign issue    = ctl_i.step && (rd_q < lim_q);

  // entry dropped by the compaction pass
  assign skip = ((cmd_q == CMD_REMOVE) && (CMPW'(pidx_q) == CMPW'(pos_q))) ||
                ((cmd_q == CMD_PURGE) && (rd_entry.pst == PST_TERMINATED));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_q[IW-1:0];
    ram_wdata = rd_entry;
    if (ctl_i.step && pend_q && !skip &&
        ((cmd_q == CMD_REMOVE) || (cmd_q == CMD_PURGE))) begin
      ram_we = 1'b1;
    end else if (ctl_i.finish && (cmd_q == CMD_INSERT) && (err_q == ERR_OK)) begin
      ram_we    = 1'b1;
      ram_waddr = occ_q[IW-1:0];
      ram_wdata = ins_q;
    end
  end

  always_comb begin
    occ_next = occ_q;
    case (cmd_q)
      CMD_INSERT: if (err_q == ERR_OK) occ_next = occ_q + CW'(1);
      CMD_REMOVE: if (err_q == ERR_OK) occ_next = occ_q - CW'(1);
      CMD_PURGE:  occ_next = wr_q;
      default:    occ_next = occ_q;
    endcase
  end

  always_comb begin
    rd_d      = rd_q;
    wr_d      = wr_q;
    lim_d     = lim_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    have_d    = have_q;
    best_id_d = best_id_q;
    best_pr_d = best_pr_q;
    err_d     = err_q;
    occ_d     = occ_q;
    out_d     = out_q;

    if (ctl_i.start) begin
      have_d = 1'b0;
      pend_d = 1'b0;
      rd_d   = '0;
      wr_d   = '0;
      lim_d  = '0;
      err_d  = ERR_OK;
      case (in_item_i.cmd)
        CMD_INSERT: begin
          if (occ_q == CW'(MaxEntries)) err_d = ERR_FULL;
        end
        CMD_FIND: lim_d = occ_q;
        CMD_REMOVE: begin
          if (occ_q == '0) begin
            err_d = ERR_EMPTY;
          end else if (CMPW'(in_item_i.position) >= CMPW'(occ_q)) begin
            err_d = ERR_POSITION;
          end else begin
            lim_d = occ_q;
            rd_d  = CW'(in_item_i.position);
            wr_d  = CW'(in_item_i.position);
          end
        end
        default: lim_d = occ_q;
      endcase
    end

    if (ctl_i.step) begin
      pend_d = issue;
      if (issue) begin
        pidx_d = rd_q;
        rd_d   = rd_q + CW'(1);
      end
      if (pend_q) begin
        if ((cmd_q == CMD_FIND) && (rd_entry.pst == PST_READY) &&
            (!have_q || (rd_entry.prio > best_pr_q))) begin
          have_d    = 1'b1;
          best_id_d = rd_entry.pid;
          best_pr_d = rd_entry.prio;
        end
        if (ram_we) wr_d = wr_q + CW'(1);
      end
    end

    if (ctl_i.finish) begin
      occ_d                = occ_next;
      out_d.error_code     = (cmd_q == CMD_FIND) ? (have_q ? ERR_OK : ERR_EMPTY) : err_q;
      out_d.found          = have_q;
      out_d.found_id       = have_q ? best_id_q : 16'd0;
      out_d.found_priority = have_q ? best_pr_q : 8'd0;
      out_d.entry_count    = 5'(occ_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      lim_q  <= '0;
      pend_q <= 1'b0;
      have_q <= 1'b0;
      cmd_q  <= CMD_INSERT;
      err_q  <= ERR_OK;
    end else begin
      occ_q  <= occ_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      lim_q  <= lim_d;
      pend_q <= pend_d;
      have_q <= have_d;
      err_q  <= err_d;
      if (ctl_i.start) cmd_q <= in_item_i.cmd;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    best_id_q <= best_id_d;
    best_pr_q <= best_pr_d;
    out_q     <= out_d;
    if (ctl_i.start) begin
      pos_q     <= in_item_i.position;
      ins_q.pid  <= in_item_i.proc_id;
      ins_q.pst  <= in_item_i.proc_state;
      ins_q.prio <= in_item_i.proc_priority;
    end
  end

  assign sts_o.scan_done = !(rd_q < lim_q) && !pend_q;
  assign out_item_o      = out_q;

`ifndef NO_ASSERTIONS
  // table never grows past its capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(MaxEntries))
    else $error("occupancy above capacity");

  // compaction write pointer never overtakes the entry being examined
  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && pend_q) |-> (wr_q <= pidx_q))
    else $error("write pointer ahead of read");

  // scan read pointer stops at its limit
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= lim_q)
    else $error("read pointer past scan limit");
`endif

endmodule

FILE: design/ptps_ctrl.sv
// ----------------------------------------------------------------------------
// ptps_ctrl
// Command sequencer: accept, scan the table, hand the result word over.
// ----------------------------------------------------------------------------
module ptps_ctrl import ptps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_ctl_t ctl_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    ctl_o.start  = 1'b0;
    ctl_o.step   = 1'b0;
    ctl_o.finish = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        ctl_o.step = 1'b1;
        if (sts_i.scan_done) state_d = StFinish;
      end
      StFinish: begin
        // wait for the output register to free up
        if (out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // a new result word never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // an accepted word always starts a scan
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.start |=> (state_q == StScan))
    else $error("accept without scan");

  // a finished command stays parked while the output is stalled
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFinish) && out_valid_q && !out_ready_i) |=> (state_q == StFinish))
    else $error("finish left under stall");
`endif

endmodule

FILE: design/process_table_priority_select_core.sv
// ----------------------------------------------------------------------------
// process_table_priority_select_core
// Sequence: accept, then a scan state reading one ram entry per cycle (find and
// purge: whole table; remove: from its position on; insert, rejected: none), then
// a finish state that waits for a free output register and stages the result word.
// Throughput: one command at a time, next accept the cycle after the word is staged.
// Reset: asynchronous, clears the occupancy and control; table contents not cleared.
// ----------------------------------------------------------------------------
module process_table_priority_select_core import ptps_pkg::*; #(
  parameter int unsigned MaxEntries = DefaultMaxEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  ptps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ptps_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule
